// ----- rtl/upcm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upcm_pkg
// Shared types, codes and helpers of the unique-prefix command matcher.
// ----------------------------------------------------------------------------
package upcm_pkg;

    localparam int CHARS_W  = 64;
    localparam int LEN_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'd97;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'd122;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'd32;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'd32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_LINE = 1'b1;

    localparam logic KIND_DECISION = 1'b0;
    localparam logic KIND_ARG      = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_KEY     = 2'd0,
        PH_ARGS    = 2'd1,
        PH_DISCARD = 2'd2
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_MATCHED   = 2'd0,
        ST_AMBIGUOUS = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z)
        begin
            r = b - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ----- rtl/upcm_kw_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upcm_kw_table
// Keyword memory: clamps and masks each keyword on write, one registered
// read port for the lookup walk.
// ----------------------------------------------------------------------------
module upcm_kw_table
    import upcm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int KEYWORD_BYTES = 8,
    localparam int IDX_W = $clog2(TABLE_ENTRIES),
    localparam int KW_W  = BYTE_W * KEYWORD_BYTES
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [CHARS_W-1:0] wr_chars,
    input  logic [LEN_W-1:0]   wr_len,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [KW_W-1:0]    rd_chars,
    output logic [LEN_W-1:0]   rd_len
);

    logic [KW_W-1:0]  chars_mem [TABLE_ENTRIES];
    logic [LEN_W-1:0] len_mem   [TABLE_ENTRIES];

    logic [LEN_W-1:0] len_clamped;
    logic [KW_W-1:0]  chars_masked;
    logic [KW_W-1:0]  rd_chars_reg;
    logic [LEN_W-1:0] rd_len_reg;

    always_comb
    begin
        if (wr_len > LEN_W'(KEYWORD_BYTES))
        begin
            len_clamped = LEN_W'(KEYWORD_BYTES);
        end
        else
        begin
            len_clamped = wr_len;
        end
        for (int i = 0; i < KEYWORD_BYTES; i++)
        begin
            if (LEN_W'(i) < len_clamped)
            begin
                chars_masked[BYTE_W*i +: BYTE_W] = wr_chars[BYTE_W*i +: BYTE_W];
            end
            else
            begin
                chars_masked[BYTE_W*i +: BYTE_W] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            chars_mem[wr_addr] <= chars_masked;
            len_mem[wr_addr]   <= len_clamped;
        end
        if (rd_en)
        begin
            rd_chars_reg <= chars_mem[rd_addr];
            rd_len_reg   <= len_mem[rd_addr];
        end
    end

    assign rd_chars = rd_chars_reg;
    assign rd_len   = rd_len_reg;

endmodule

// ----- rtl/unique_prefix_command_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_prefix_command_match
// Keyword table with unique-prefix lookup of the first word of a command
// line; argument bytes of a matched line pass out upper-cased.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------
//   in      | in_valid/in_stall  | operation, keyword_chars, keyword_length,
//           |                    | line_byte, line_end
//   out     | out_valid/out_stall| result_kind, match_status, keyword_index,
//           |                    | argument_byte, last
//
// Keyword loads and line bytes without a decision need no lookup; the next
// item can follow at once unless the output is stalled. A decision walks
// the keyword memory, which has one read port, one stored entry per cycle,
// and holds in_stall high until it is handed out.
// Reset clears control state and the keyword count; memory contents stay
// undefined and need no clearing pass, since only entries below the count
// are read. in_stall is high during a lookup and while the output register
// holds an item that is stalled.
// ----------------------------------------------------------------------------
module unique_prefix_command_match
    import upcm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int KEYWORD_BYTES = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic [CHARS_W-1:0]  keyword_chars,
    input  logic [LEN_W-1:0]    keyword_length,
    input  logic [BYTE_W-1:0]   line_byte,
    input  logic                line_end,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                result_kind,
    output logic [STATUS_W-1:0] match_status,
    output logic [INDEX_W-1:0]  keyword_index,
    output logic [BYTE_W-1:0]   argument_byte,
    output logic                last
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int KW_W  = BYTE_W * KEYWORD_BYTES;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [KW_W-1:0]    key_buf_reg, key_buf_next;
    logic [LEN_W-1:0]   key_len_reg, key_len_next;
    logic               key_over_reg, key_over_next;
    logic               end_pend_reg, end_pend_next;
    logic [CNT_W-1:0]   scan_addr_reg, scan_addr_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               exact_hit_reg, exact_hit_next;
    logic [IDX_W-1:0]   exact_idx_reg, exact_idx_next;
    logic               have_reg, have_next;
    logic [IDX_W-1:0]   found_idx_reg, found_idx_next;
    logic               many_reg, many_next;

    logic               out_valid_reg, out_valid_next;
    logic               result_kind_reg, result_kind_next;
    status_t            match_status_reg, match_status_next;
    logic [INDEX_W-1:0] keyword_index_reg, keyword_index_next;
    logic [BYTE_W-1:0]  argument_byte_reg, argument_byte_next;
    logic               last_reg, last_next;

    logic               stall_int;
    logic               in_accept;
    logic               is_load;
    logic               is_line;
    logic               in_key_phase;
    logic [BYTE_W-1:0]  byte_up;
    logic               wr_en;
    logic               arg_load;
    logic               start_scan;
    logic               issue_rd;
    logic               scan_over;
    logic               out_free;
    logic               dec_load;

    logic [KW_W-1:0]    rd_chars;
    logic [LEN_W-1:0]   rd_len;
    logic [KW_W-1:0]    key_mask;
    logic               part_eq;
    logic               hit_exact;
    logic               hit_prefix;

    status_t            dec_status;
    logic [IDX_W-1:0]   dec_idx;

    upcm_kw_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEYWORD_BYTES (KEYWORD_BYTES)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (count_reg[IDX_W-1:0]),
        .wr_chars (keyword_chars),
        .wr_len   (keyword_length),
        .rd_en    (issue_rd),
        .rd_addr  (scan_addr_reg[IDX_W-1:0]),
        .rd_chars (rd_chars),
        .rd_len   (rd_len)
    );

    // control outputs
    always_comb
    begin
        stall_int  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
        in_accept  = in_valid && !stall_int;
        is_load    = in_accept && (operation == OP_LOAD);
        is_line    = in_accept && (operation == OP_LINE);
        byte_up    = upcase(line_byte);
        wr_en      = is_load && (count_reg < CNT_W'(TABLE_ENTRIES));
        in_key_phase = (phase_reg != PH_ARGS) && (phase_reg != PH_DISCARD);
        arg_load   = is_line && (phase_reg == PH_ARGS);
        start_scan = is_line && in_key_phase && ((byte_up == CHAR_SPACE) || line_end);
        issue_rd   = (state_reg == S_SCAN) && (scan_addr_reg < count_reg);
        scan_over  = (state_reg == S_SCAN) && !issue_rd && !cmp_valid_reg;
        out_free   = !out_valid_reg || !out_stall;
        dec_load   = (state_reg == S_DONE) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start_scan)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_over)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (dec_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // compare one stored entry against the key
    always_comb
    begin
        for (int i = 0; i < KEYWORD_BYTES; i++)
        begin
            key_mask[BYTE_W*i +: BYTE_W] = (LEN_W'(i) < key_len_reg) ? 8'hFF : 8'h00;
        end
        part_eq    = (rd_chars & key_mask) == key_buf_reg;
        hit_exact  = part_eq && (rd_len == key_len_reg);
        hit_prefix = part_eq && (key_len_reg <= rd_len);
    end

    always_comb
    begin
        dec_idx = '0;
        if (key_len_reg == '0 || key_over_reg)
        begin
            dec_status = ST_NOT_FOUND;
        end
        else if (exact_hit_reg)
        begin
            dec_status = ST_MATCHED;
            dec_idx    = exact_idx_reg;
        end
        else if (many_reg)
        begin
            dec_status = ST_AMBIGUOUS;
        end
        else if (have_reg)
        begin
            dec_status = ST_MATCHED;
            dec_idx    = found_idx_reg;
        end
        else
        begin
            dec_status = ST_NOT_FOUND;
        end
    end

    always_comb
    begin
        count_next     = count_reg + CNT_W'(wr_en);
        phase_next     = phase_reg;
        key_buf_next   = key_buf_reg;
        key_len_next   = key_len_reg;
        key_over_next  = key_over_reg;
        end_pend_next  = end_pend_reg;
        scan_addr_next = scan_addr_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = scan_addr_reg[IDX_W-1:0];
        exact_hit_next = exact_hit_reg;
        exact_idx_next = exact_idx_reg;
        have_next      = have_reg;
        found_idx_next = found_idx_reg;
        many_next      = many_reg;

        // line byte
        if (is_line)
        begin
            case (phase_reg) inside
                PH_ARGS, PH_DISCARD:
                begin
                    if (line_end)
                    begin
                        phase_next = PH_KEY;
                    end
                end
                default:
                begin
                    if (byte_up != CHAR_SPACE)
                    begin
                        if (key_len_reg < LEN_W'(KEYWORD_BYTES))
                        begin
                            for (int i = 0; i < KEYWORD_BYTES; i++)
                            begin
                                if (LEN_W'(i) == key_len_reg)
                                begin
                                    key_buf_next[BYTE_W*i +: BYTE_W] = byte_up;
                                end
                            end
                            key_len_next = key_len_reg + LEN_W'(1);
                        end
                        else
                        begin
                            key_over_next = 1'b1;
                        end
                    end
                end
            endcase
        end

        // start lookup
        if (start_scan)
        begin
            end_pend_next  = line_end;
            scan_addr_next = '0;
            exact_hit_next = 1'b0;
            have_next      = 1'b0;
            many_next      = 1'b0;
        end

        // walk the table
        if (state_reg == S_SCAN)
        begin
            cmp_valid_next = issue_rd;
            if (issue_rd)
            begin
                scan_addr_next = scan_addr_reg + CNT_W'(1);
            end
            if (cmp_valid_reg && !exact_hit_reg)
            begin
                if (hit_exact)
                begin
                    exact_hit_next = 1'b1;
                    exact_idx_next = cmp_idx_reg;
                end
                else if (hit_prefix)
                begin
                    if (!have_reg)
                    begin
                        have_next      = 1'b1;
                        found_idx_next = cmp_idx_reg;
                    end
                    else
                    begin
                        many_next = 1'b1;
                    end
                end
            end
        end

        // hand out decision
        if (dec_load)
        begin
            key_buf_next  = '0;
            key_len_next  = '0;
            key_over_next = 1'b0;
            if (end_pend_reg)
            begin
                phase_next = PH_KEY;
            end
            else if (dec_status == ST_MATCHED)
            begin
                phase_next = PH_ARGS;
            end
            else
            begin
                phase_next = PH_DISCARD;
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next     = out_valid_reg && out_stall;
        result_kind_next   = result_kind_reg;
        match_status_next  = match_status_reg;
        keyword_index_next = keyword_index_reg;
        argument_byte_next = argument_byte_reg;
        last_next          = last_reg;
        if (arg_load)
        begin
            out_valid_next     = 1'b1;
            result_kind_next   = KIND_ARG;
            match_status_next  = ST_MATCHED;
            keyword_index_next = '0;
            argument_byte_next = byte_up;
            last_next          = line_end;
        end
        else if (dec_load)
        begin
            out_valid_next     = 1'b1;
            result_kind_next   = KIND_DECISION;
            match_status_next  = dec_status;
            keyword_index_next = INDEX_W'(dec_idx);
            argument_byte_next = '0;
            last_next          = end_pend_reg || (dec_status != ST_MATCHED);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_KEY;
            count_reg     <= '0;
            key_buf_reg   <= '0;
            key_len_reg   <= '0;
            key_over_reg  <= 1'b0;
            end_pend_reg  <= 1'b0;
            scan_addr_reg <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            key_buf_reg   <= key_buf_next;
            key_len_reg   <= key_len_next;
            key_over_reg  <= key_over_next;
            end_pend_reg  <= end_pend_next;
            scan_addr_reg <= scan_addr_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg       <= cmp_idx_next;
        exact_hit_reg     <= exact_hit_next;
        exact_idx_reg     <= exact_idx_next;
        have_reg          <= have_next;
        found_idx_reg     <= found_idx_next;
        many_reg          <= many_next;
        result_kind_reg   <= result_kind_next;
        match_status_reg  <= match_status_next;
        keyword_index_reg <= keyword_index_next;
        argument_byte_reg <= argument_byte_next;
        last_reg          <= last_next;
    end

    assign in_stall      = stall_int;
    assign out_valid     = out_valid_reg;
    assign result_kind   = result_kind_reg;
    assign match_status  = match_status_reg;
    assign keyword_index = keyword_index_reg;
    assign argument_byte = argument_byte_reg;
    assign last          = last_reg;

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken during lookup");

    a_cmp_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (CNT_W'(cmp_idx_reg) < count_reg))
        else $error("compare beyond loaded entries");

    a_nomatch_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_kind_reg == KIND_DECISION
            && match_status_reg != ST_MATCHED) |-> (keyword_index_reg == '0))
        else $error("index set on unmatched decision");

    a_decision_shown: assert property (@(posedge clk) disable iff (!rst_n)
        dec_load |=> (out_valid_reg && result_kind_reg == KIND_DECISION))
        else $error("decision not loaded into output register");

endmodule

// ----- sim/unique_prefix_command_match_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_prefix_command_match_tb
// Loads keywords and sends command lines byte by byte, with random gaps and
// output stalls. A scoreboard class keeps its own keyword table and line
// state, predicts each decision and argument byte, and compares every
// accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module unique_prefix_command_match_tb
    import upcm_pkg::*;
;

    localparam int KW_ENTRIES = 32;
    localparam int KW_BYTES   = 8;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        logic [BYTE_W-1:0]   arg;
        logic                last;
    } cmd_result_t;

    class keyword_match_sb;
        logic [CHARS_W-1:0] store [KW_ENTRIES];
        int                 lens [KW_ENTRIES];
        int                 count;
        logic [CHARS_W-1:0] key_buf;
        int                 key_len;
        bit                 key_overlong;
        phase_t             phase;
        cmd_result_t        awaited [$];
        int                 errors;

        function new();
            count        = 0;
            key_buf      = '0;
            key_len      = 0;
            key_overlong = 1'b0;
            phase        = PH_KEY;
            errors       = 0;
        endfunction

        function logic [CHARS_W-1:0] byte_mask(int n);
            if (n >= KW_BYTES)
            begin
                return '1;
            end
            return (64'd1 << (8 * n)) - 64'd1;
        endfunction

        function logic [BYTE_W-1:0] raise_case(logic [BYTE_W-1:0] b);
            if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z)
            begin
                return b - CASE_OFFSET;
            end
            return b;
        endfunction

        function void lookup(output logic [STATUS_W-1:0] st, output logic [INDEX_W-1:0] idx);
            logic [CHARS_W-1:0] part;
            bit                 have;
            bit                 many;
            int                 found;
            int                 i;
            have  = 1'b0;
            many  = 1'b0;
            found = 0;
            idx   = '0;
            st    = ST_NOT_FOUND;
            if (key_len == 0 || key_overlong)
            begin
                return;
            end
            for (i = 0; i < count; i++)
            begin
                part = store[i] & byte_mask(key_len);
                if (part == key_buf)
                begin
                    if (lens[i] == key_len)
                    begin
                        idx = INDEX_W'(i);
                        st  = ST_MATCHED;
                        return;
                    end
                    if (key_len <= lens[i])
                    begin
                        if (!have)
                        begin
                            have  = 1'b1;
                            found = i;
                        end
                        else
                        begin
                            many = 1'b1;
                        end
                    end
                end
            end
            if (many)
            begin
                st = ST_AMBIGUOUS;
            end
            else if (have)
            begin
                st  = ST_MATCHED;
                idx = INDEX_W'(found);
            end
        endfunction

        function void note_input(logic op, logic [CHARS_W-1:0] chars, logic [LEN_W-1:0] len_in,
                                 logic [BYTE_W-1:0] lb, logic lend);
            int                  klen;
            logic [BYTE_W-1:0]   b;
            logic [STATUS_W-1:0] st;
            logic [INDEX_W-1:0]  idx;
            cmd_result_t         r;
            if (op == OP_LOAD)
            begin
                if (count >= KW_ENTRIES)
                begin
                    return;
                end
                klen = int'(len_in);
                if (klen > KW_BYTES)
                begin
                    klen = KW_BYTES;
                end
                store[count] = chars & byte_mask(klen);
                lens[count]  = klen;
                count++;
                return;
            end
            b = raise_case(lb);
            if (phase == PH_ARGS)
            begin
                r.kind   = KIND_ARG;
                r.status = ST_MATCHED;
                r.index  = '0;
                r.arg    = b;
                r.last   = lend;
                awaited.insert(awaited.size(), r);
                if (lend)
                begin
                    phase = PH_KEY;
                end
                return;
            end
            if (phase == PH_DISCARD)
            begin
                if (lend)
                begin
                    phase = PH_KEY;
                end
                return;
            end
            if (b != CHAR_SPACE)
            begin
                if (key_len < KW_BYTES)
                begin
                    key_buf = key_buf | (CHARS_W'(b) << (8 * key_len));
                    key_len++;
                end
                else
                begin
                    key_overlong = 1'b1;
                end
                if (!lend)
                begin
                    return;
                end
            end
            lookup(st, idx);
            r.kind   = KIND_DECISION;
            r.status = st;
            r.index  = idx;
            r.arg    = '0;
            r.last   = lend || (st != ST_MATCHED);
            awaited.insert(awaited.size(), r);
            key_buf      = '0;
            key_len      = 0;
            key_overlong = 1'b0;
            if (lend)
            begin
                phase = PH_KEY;
            end
            else
            begin
                phase = (st == ST_MATCHED) ? PH_ARGS : PH_DISCARD;
            end
        endfunction

        function void compare(string name, int want, int got);
            if (want != got)
            begin
                $error("%s expected %0d actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_output(cmd_result_t got);
            cmd_result_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: kind %0d status %0d index %0d byte %0d last %0d",
                       got.kind, got.status, got.index, got.arg, got.last);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare("result_kind", int'(want.kind), int'(got.kind));
            compare("match_status", int'(want.status), int'(got.status));
            compare("keyword_index", int'(want.index), int'(got.index));
            compare("argument_byte", int'(want.arg), int'(got.arg));
            compare("last", int'(want.last), int'(got.last));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                operation;
    logic [CHARS_W-1:0]  keyword_chars;
    logic [LEN_W-1:0]    keyword_length;
    logic [BYTE_W-1:0]   line_byte;
    logic                line_end;
    logic                out_valid;
    logic                out_stall;
    logic                result_kind;
    logic [STATUS_W-1:0] match_status;
    logic [INDEX_W-1:0]  keyword_index;
    logic [BYTE_W-1:0]   argument_byte;
    logic                last;

    keyword_match_sb sb;
    bit              quiet;
    int              items_done;

    unique_prefix_command_match u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .keyword_chars  (keyword_chars),
        .keyword_length (keyword_length),
        .line_byte      (line_byte),
        .line_end       (line_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .match_status   (match_status),
        .keyword_index  (keyword_index),
        .argument_byte  (argument_byte),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [CHARS_W-1:0] pack_kw(string s);
        logic [CHARS_W-1:0] c;
        c = '0;
        for (int i = 0; i < s.len() && i < KW_BYTES; i++)
        begin
            c[8*i +: 8] = s[i];
        end
        return c;
    endfunction

    function automatic void random_keyword(output logic [CHARS_W-1:0] c,
                                           output logic [LEN_W-1:0] l);
        int r;
        r = $urandom_range(0, 99);
        c = {$urandom, $urandom};
        if (r < 80)
        begin
            l = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(5, 8))
                                            : LEN_W'($urandom_range(1, 4));
        end
        else if (r < 88)
        begin
            l = LEN_W'($urandom_range(9, 15));
        end
        else if (r < 93)
        begin
            l = '0;
        end
        else
        begin
            l = LEN_W'($urandom_range(0, 15));
            return;
        end
        for (int k = 0; k < KW_BYTES; k++)
        begin
            if (k < int'(l))
            begin
                c[8*k +: 8] = BYTE_W'($urandom_range(65, 70));
            end
        end
    endfunction

    task automatic send_item(logic op, logic [CHARS_W-1:0] c, logic [LEN_W-1:0] l,
                             logic [BYTE_W-1:0] b, logic e);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation      = op;
        keyword_chars  = c;
        keyword_length = l;
        line_byte      = b;
        line_end       = e;
        in_valid       = 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_input(op, c, l, b, e);
        items_done++;
        if ($urandom_range(0, 149) == 0)
        begin
            quiet = !quiet;
        end
    endtask

    task automatic send_load(logic [CHARS_W-1:0] c, logic [LEN_W-1:0] l);
        send_item(OP_LOAD, c, l, BYTE_W'($urandom), 1'($urandom));
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] b, logic e);
        send_item(OP_LINE, {$urandom, $urandom}, LEN_W'($urandom), b, e);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    task automatic random_load();
        logic [CHARS_W-1:0] c;
        logic [LEN_W-1:0]   l;
        random_keyword(c, l);
        send_load(c, l);
    endtask

    task automatic random_line();
        logic [BYTE_W-1:0]  q [$];
        logic [BYTE_W-1:0]  b;
        logic [CHARS_W-1:0] kc;
        int                 r;
        int                 pick;
        int                 kl;
        int                 n;
        r = $urandom_range(0, 99);
        if (r < 70 && sb.count > 0)
        begin
            pick = $urandom_range(0, sb.count - 1);
            kc   = sb.store[pick];
            kl   = sb.lens[pick];
            n    = $urandom_range(1, (kl > 0) ? kl : 3);
            for (int i = 0; i < n; i++)
            begin
                b = (i < kl) ? kc[8*i +: 8] : BYTE_W'($urandom_range(65, 70));
                if (b >= 8'd65 && b <= 8'd90 && $urandom_range(0, 1) == 1)
                begin
                    b = b + CASE_OFFSET;
                end
                q.insert(q.size(), b);
            end
        end
        else if (r < 85)
        begin
            n = $urandom_range(1, 11);
            for (int i = 0; i < n; i++)
            begin
                q.insert(q.size(), BYTE_W'($urandom_range(0, 1) ? $urandom_range(65, 70)
                                                                : $urandom_range(97, 102)));
            end
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                q.insert(q.size(),
                         ($urandom_range(0, 3) == 0) ? CHAR_SPACE : BYTE_W'($urandom));
            end
        end
        if (r < 85 && $urandom_range(0, 9) < 6)
        begin
            q.insert(q.size(), CHAR_SPACE);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 3))
                    0: q.insert(q.size(), CHAR_SPACE);
                    1: q.insert(q.size(), BYTE_W'($urandom_range(97, 122)));
                    default: q.insert(q.size(), BYTE_W'($urandom));
                endcase
            end
        end
        for (int i = 0; i < q.size(); i++)
        begin
            if ($urandom_range(0, 59) == 0)
            begin
                random_load();
            end
            send_byte(q[i], i == q.size() - 1);
        end
    endtask

    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            n = pick_gap();
            @(negedge clk);
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
            repeat ($urandom_range(0, 4)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_output({result_kind, match_status, keyword_index, argument_byte, last});
        end
    end

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = OP_LOAD;
        keyword_chars  = '0;
        keyword_length = '0;
        line_byte      = '0;
        line_end       = 1'b0;
        quiet          = 1'b0;
        items_done     = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_load(pack_kw("LIST"), 4'd4);
        send_load(pack_kw("LO"), 4'd2);
        send_load(pack_kw("LOAD"), 4'd4);
        send_load(pack_kw("help"), 4'd4);
        send_load({$urandom, $urandom}, 4'd0);
        send_load('1, 4'd15);
        send_text("lo");
        send_text("L");
        send_byte("L", 1'b0);
        send_byte("I", 1'b0);
        send_load(pack_kw("HELP"), 4'd4);
        send_byte(" ", 1'b0);
        send_byte("z", 1'b1);
        send_text(" ");
        send_text(" A");
        send_text("H");
        send_text("abcdefghi");

        while (items_done < 1350)
        begin
            if ($urandom_range(0, (sb.count < KW_ENTRIES) ? 19 : 59) == 0)
            begin
                random_load();
            end
            else
            begin
                random_line();
            end
        end
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (48) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
